// File: rtl/cbip_pkg.sv
// Shared types, widths and character constants for the custom base integer parser.
// No dependencies; imported by every module of the block except cbip_ram.
package cbip_pkg;

    localparam int DEF_MAX_SYMBOLS = 128;
    localparam int SYMBOL_INDEX_W  = 7;
    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int REV_DEPTH       = 1 << CHAR_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_FETCH  = 3'd2,
        ST_EXEC   = 3'd3,
        ST_RESULT = 3'd4
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic fetch;
        logic exec;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic want_result;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/cbip_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cbip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cbip_ctrl.sv
// Sequencing state machine for the parser: clearing pass, accept, fetch, execute, result.
// Depends on cbip_pkg.
module cbip_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  cbip_pkg::status_t status,
    output cbip_pkg::cmd_t    cmd
);
    import cbip_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = status.want_result ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/cbip_dp.sv
// Parser datapath: symbol table and reverse map, validity checks, parse phase,
// multiply-accumulate and result register. Depends on cbip_pkg and cbip_ram.
module cbip_dp #(
    parameter int MAX_SYMBOLS = cbip_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cbip_pkg::cmd_t                       cmd,
    output cbip_pkg::status_t                    status,
    input  logic                                 opcode,
    input  logic [cbip_pkg::SYMBOL_INDEX_W-1:0]  symbol_index,
    input  logic [cbip_pkg::CHAR_W-1:0]          char_code,
    input  logic                                 last,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [cbip_pkg::VALUE_W-1:0]  value,
    output logic                                 base_valid
);
    import cbip_pkg::*;

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int LW = $clog2(MAX_SYMBOLS + 1);
    localparam int RW = $clog2(REV_DEPTH);

    // captured transaction
    logic                      op_reg;
    logic [SYMBOL_INDEX_W-1:0] idx_reg;
    logic [CHAR_W-1:0]         chr_reg;
    logic                      last_reg;

    // alphabet state
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          bad_reg;
    logic          bad_next;

    // parse state
    phase_t             phase_reg;
    phase_t             phase_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_base_reg;

    logic [RW-1:0] clr_cnt_reg;

    // memories
    logic              sym_we;
    logic [AW-1:0]     sym_waddr;
    logic [CHAR_W-1:0] sym_rdata;
    logic              rev_we;
    logic [RW-1:0]     rev_waddr;
    logic [AW-1:0]     rev_wdata;
    logic [AW-1:0]     rev_rdata;

    // decode
    logic          is_blank;
    logic          is_sign;
    logic          sym_illegal;
    logic [LW-1:0] eff_len;
    logic          eff_bad;
    logic          hit_load;
    logic          hit_text;
    logic          store_ok;
    logic          base_ok;

    cbip_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_SYMBOLS)
    ) u_sym_ram (
        .clk  (clk),
        .we   (sym_we),
        .waddr(sym_waddr),
        .wdata(chr_reg),
        .re   (cmd.fetch),
        .raddr(rev_rdata),
        .rdata(sym_rdata)
    );

    cbip_ram #(
        .WIDTH(AW),
        .DEPTH(REV_DEPTH)
    ) u_rev_ram (
        .clk  (clk),
        .we   (rev_we),
        .waddr(rev_waddr),
        .wdata(rev_wdata),
        .re   (cmd.capture),
        .raddr(char_code),
        .rdata(rev_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            idx_reg  <= symbol_index;
            chr_reg  <= char_code;
            last_reg <= last;
        end
        if (cmd.emit)
        begin
            out_value_reg <= base_ok ? $signed(neg_reg ? (-acc_reg) : acc_reg) : '0;
            out_base_reg  <= base_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            len_reg       <= len_next;
            bad_reg       <= bad_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign is_blank = (chr_reg == CH_SPACE) || (chr_reg == CH_TAB) || (chr_reg == CH_LF)
                   || (chr_reg == CH_VT) || (chr_reg == CH_FF) || (chr_reg == CH_CR);
    assign is_sign  = (chr_reg == CH_PLUS) || (chr_reg == CH_MINUS);
    assign sym_illegal = is_sign || (chr_reg < CH_SPACE) || (chr_reg > CH_TILDE);

    // restart at index 0 empties the alphabet first
    assign eff_len = (idx_reg == '0) ? '0 : len_reg;
    assign eff_bad = (idx_reg == '0) ? 1'b0 : bad_reg;

    // reverse map entry is trusted only if it points inside the alphabet and matches
    assign hit_load = (LW'(rev_rdata) < eff_len) && (sym_rdata == chr_reg);
    assign hit_text = (LW'(rev_rdata) < len_reg) && (sym_rdata == chr_reg);

    assign store_ok = (32'(idx_reg) == 32'(eff_len)) && (chr_reg != CH_NUL)
                   && (32'(eff_len) < 32'(MAX_SYMBOLS));

    assign base_ok = !bad_reg && (len_reg >= LW'(2));

    assign sym_we    = cmd.exec && (op_reg == OP_LOAD) && store_ok;
    assign sym_waddr = AW'(eff_len);

    always_comb
    begin
        if (cmd.clear)
        begin
            rev_we    = 1'b1;
            rev_waddr = clr_cnt_reg;
            rev_wdata = '0;
        end
        else
        begin
            rev_we    = sym_we && !hit_load;
            rev_waddr = chr_reg;
            rev_wdata = AW'(eff_len);
        end
    end

    always_comb
    begin
        logic consumed;
        consumed   = 1'b0;
        len_next   = len_reg;
        bad_next   = bad_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (cmd.exec && (op_reg == OP_LOAD))
        begin
            len_next = store_ok ? (eff_len + 1'b1) : eff_len;
            bad_next = eff_bad || (store_ok && (sym_illegal || hit_load
                       || ((eff_len != '0) && (chr_reg == CH_SPACE))));
        end
        else if (cmd.exec)
        begin
            if (phase_next == PH_SPACE)
            begin
                if (is_blank)
                begin
                    consumed = 1'b1;
                end
                else
                begin
                    phase_next = PH_SIGN;
                end
            end
            if (!consumed && (phase_next == PH_SIGN))
            begin
                if (is_sign)
                begin
                    consumed = 1'b1;
                    if (chr_reg == CH_MINUS)
                    begin
                        neg_next = !neg_reg;
                    end
                end
                else
                begin
                    phase_next = PH_DIGIT;
                end
            end
            if (!consumed && (phase_next == PH_DIGIT))
            begin
                if ((chr_reg != CH_NUL) && hit_text)
                begin
                    acc_next = VALUE_W'(acc_reg * VALUE_W'(len_reg)) + VALUE_W'(rev_rdata);
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end
        else if (cmd.emit)
        begin
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign status.clear_done  = &clr_cnt_reg;
    assign status.want_result = (op_reg == OP_TEXT) && last_reg;
    assign status.out_busy    = out_valid_reg && !result_ready;

    assign result_valid = out_valid_reg;
    assign value        = out_value_reg;
    assign base_valid   = out_base_reg;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !result_ready))
        else $error("result overwritten while still pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= 32'(MAX_SYMBOLS))
        else $error("alphabet length beyond capacity");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (phase_reg == PH_SPACE) && !neg_reg && (acc_reg == '0))
        else $error("parser not rearmed after result");

    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_base_reg) |-> (out_value_reg == '0))
        else $error("nonzero value with invalid base");
`endif

endmodule

// File: rtl/custom_base_integer_parser.sv
// Base-N integer parser with loadable digit alphabet; each transaction passes through
// accept (reverse-map read), fetch (symbol RAM read) and execute, in an order set by
// the two dependent reads of the reverse map and symbol RAMs; a final text transaction
// adds a result state that loads the result register and waits while the output is busy.
// Transactions do not overlap. After reset the reverse map is cleared with item_ready low.
// Depends on cbip_pkg, cbip_ctrl, cbip_dp, cbip_ram.
module custom_base_integer_parser #(
    parameter int MAX_SYMBOLS = cbip_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                opcode,
    input  logic [cbip_pkg::SYMBOL_INDEX_W-1:0] symbol_index,
    input  logic [cbip_pkg::CHAR_W-1:0]         char_code,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [cbip_pkg::VALUE_W-1:0] value,
    output logic                                base_valid
);
    import cbip_pkg::*;

    cmd_t    cmd;
    status_t status;

    cbip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cbip_dp #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (opcode),
        .symbol_index(symbol_index),
        .char_code   (char_code),
        .last        (last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .value       (value),
        .base_valid  (base_valid)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for custom_base_integer_parser.
// Streams alphabet loads and text strings, predicts each parsed value, checks every result.
// Depends on cbip_pkg and the RTL of the block; reads no files.
module tb_top;
    import cbip_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RAND_ITEMS   = 240;

    typedef struct packed {
        logic                      opcode;
        logic [SYMBOL_INDEX_W-1:0] idx;
        logic [CHAR_W-1:0]         ch;
        logic                      last;
    } char_txn_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      base_valid;
    } parse_res_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic                       opcode = OP_LOAD;
    logic [SYMBOL_INDEX_W-1:0]  symbol_index = '0;
    logic [CHAR_W-1:0]          char_code = CH_NUL;
    logic                       last = 1'b0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [VALUE_W-1:0]  value;
    logic                       base_valid;

    char_txn_t   txn_q[$];
    parse_res_t  parsed_q[$];

    // predictor state
    logic [CHAR_W-1:0]  sym_tab[DEF_MAX_SYMBOLS];
    int                 sym_len = 0;
    logic               sym_bad = 1'b0;
    phase_t             parse_ph = PH_SPACE;
    logic               neg_flag = 1'b0;
    logic [VALUE_W-1:0] acc = '0;

    // generator's view of the alphabet, used to pick digits
    logic [CHAR_W-1:0]  gen_syms[$];
    int                 gen_count = 0;

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left;
    int   mismatch_count = 0;
    int   quiet_cycles;

    custom_base_integer_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .symbol_index (symbol_index),
        .char_code    (char_code),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .base_valid   (base_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void parse_txn(input char_txn_t t);
        parse_res_t   r;
        logic [VALUE_W-1:0] mag;
        logic         consumed;
        logic         hit;
        logic         ok;
        if (t.opcode == OP_LOAD)
        begin
            if (t.idx == '0)
            begin
                sym_len = 0;
                sym_bad = 1'b0;
            end
            if (int'(t.idx) != sym_len || t.ch == CH_NUL || sym_len >= DEF_MAX_SYMBOLS)
                return;
            if (t.ch == CH_PLUS || t.ch == CH_MINUS || t.ch < CH_SPACE || t.ch > CH_TILDE)
                sym_bad = 1'b1;
            if (sym_len > 0 && t.ch == CH_SPACE)
                sym_bad = 1'b1;
            for (int k = 0; k < sym_len; k++)
                if (sym_tab[k] == t.ch)
                    sym_bad = 1'b1;
            sym_tab[sym_len] = t.ch;
            sym_len++;
            return;
        end
        consumed = 1'b0;
        if (parse_ph == PH_SPACE)
        begin
            if (t.ch == CH_SPACE || t.ch == CH_TAB || t.ch == CH_LF || t.ch == CH_VT ||
                t.ch == CH_FF || t.ch == CH_CR)
                consumed = 1'b1;
            else
                parse_ph = PH_SIGN;
        end
        if (!consumed && parse_ph == PH_SIGN)
        begin
            if (t.ch == CH_PLUS || t.ch == CH_MINUS)
            begin
                if (t.ch == CH_MINUS)
                    neg_flag = ~neg_flag;
                consumed = 1'b1;
            end
            else
                parse_ph = PH_DIGIT;
        end
        if (!consumed && parse_ph == PH_DIGIT)
        begin
            hit = 1'b0;
            if (t.ch != CH_NUL)
                for (int k = 0; k < sym_len; k++)
                    if (!hit && sym_tab[k] == t.ch)
                    begin
                        acc = acc * VALUE_W'(sym_len) + VALUE_W'(k);
                        hit = 1'b1;
                    end
            if (!hit)
                parse_ph = PH_DONE;
        end
        if (t.last)
        begin
            ok = !sym_bad && sym_len >= 2;
            mag = neg_flag ? -acc : acc;
            r.value = ok ? mag : '0;
            r.base_valid = ok;
            parsed_q.push_back(r);
            parse_ph = PH_SPACE;
            neg_flag = 1'b0;
            acc = '0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("tb_top: mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // driver: presents queued transactions, predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin : drive
        char_txn_t nxt;
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            opcode       <= OP_LOAD;
            symbol_index <= '0;
            char_code    <= CH_NUL;
            last         <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                parse_txn('{opcode: opcode, idx: symbol_index, ch: char_code, last: last});
            if (!item_valid || item_ready)
            begin
                if (txn_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = txn_q.pop_front();
                    item_valid   <= 1'b1;
                    opcode       <= nxt.opcode;
                    symbol_index <= nxt.idx;
                    char_code    <= nxt.ch;
                    last         <= nxt.last;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_req)
        begin
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        parse_res_t exp_res;
        if (rst_n && result_valid && result_ready)
        begin
            if (parsed_q.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d base_valid=%0b",
                                          value, base_valid));
            else
            begin
                exp_res = parsed_q.pop_front();
                if (value !== exp_res.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              value, exp_res.value));
                if (base_valid !== exp_res.base_valid)
                    report_mismatch($sformatf("base_valid got %0b want %0b",
                                              base_valid, exp_res.base_valid));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= LIMIT_CYCLES)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input logic op, input logic [SYMBOL_INDEX_W-1:0] idx,
                             input logic [CHAR_W-1:0] ch, input logic lst);
        txn_q.push_back('{opcode: op, idx: idx, ch: ch, last: lst});
        gen_count++;
    endtask

    // in-order alphabet load, optionally with one flaw
    task automatic load_alphabet(input int n, input bit flawed);
        logic [CHAR_W-1:0] pool[$];
        logic [CHAR_W-1:0] syms[$];
        int                j;
        int                p;
        for (int v = 33; v <= 126; v++)
            if (CHAR_W'(v) != CH_PLUS && CHAR_W'(v) != CH_MINUS)
                pool.push_back(CHAR_W'(v));
        if ($urandom_range(3) == 0)
            syms.push_back(CH_SPACE);
        while (syms.size() < n && pool.size() != 0)
        begin
            j = $urandom_range(pool.size() - 1);
            syms.push_back(pool[j]);
            pool.delete(j);
        end
        if (flawed)
        begin
            p = $urandom_range(syms.size() - 1);
            case ($urandom_range(4))
                0: syms[p] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
                1: syms.push_back(syms[0]);
                2: syms.push_back(CH_SPACE);
                3: syms[p] = $urandom_range(1) ? CHAR_W'($urandom_range(1, 31))
                                               : CHAR_W'($urandom_range(127, 255));
                default: syms = '{syms[0]};
            endcase
        end
        for (int k = 0; k < syms.size(); k++)
            push_item(OP_LOAD, SYMBOL_INDEX_W'(k), syms[k], 1'($urandom_range(1)));
        gen_syms = syms;
    endtask

    // blanks, signs, digits of the current alphabet, then an ending
    task automatic push_string();
        logic [CHAR_W-1:0] txt[$];
        logic [CHAR_W-1:0] blanks[6] = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
        logic [CHAR_W-1:0] c;
        int                n_digits;
        int                mid;
        repeat ($urandom_range(3))
            txt.push_back(blanks[$urandom_range(5)]);
        repeat ($urandom_range(3))
            txt.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        n_digits = ($urandom_range(4) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        repeat (n_digits)
            txt.push_back(gen_syms.size() != 0 ? gen_syms[$urandom_range(gen_syms.size() - 1)]
                                               : CHAR_W'($urandom_range(255)));
        case ($urandom_range(2))
            0: ;
            1:
            begin
                txt.push_back(CH_NUL);
                repeat ($urandom_range(2))
                    txt.push_back(CHAR_W'($urandom_range(255)));
            end
            default: txt.push_back(CHAR_W'($urandom_range(1, 255)));
        endcase
        mid = ($urandom_range(19) == 0) ? $urandom_range(txt.size() - 1) : -1;
        for (int k = 0; k < txt.size(); k++)
        begin
            // alphabet grows in the middle of a string
            if (k == mid && gen_syms.size() < DEF_MAX_SYMBOLS)
            begin
                c = CHAR_W'($urandom_range(33, 126));
                push_item(OP_LOAD, SYMBOL_INDEX_W'(gen_syms.size()), c, 1'b0);
                gen_syms.push_back(c);
            end
            push_item(OP_TEXT, SYMBOL_INDEX_W'($urandom_range(127)), txt[k],
                      k == txt.size() - 1);
        end
    endtask

    task automatic wait_sent();
        while (txn_q.size() != 0 || item_valid)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall);
        int stop_at;
        int sel;
        @(negedge clk);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        stop_at = gen_count + RAND_ITEMS / 4;
        while (gen_count < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
            begin
                // full-depth alphabet of arbitrary nonzero bytes
                gen_syms.delete();
                for (int k = 0; k < DEF_MAX_SYMBOLS; k++)
                begin
                    gen_syms.push_back(CHAR_W'($urandom_range(1, 255)));
                    push_item(OP_LOAD, SYMBOL_INDEX_W'(k), gen_syms[k], 1'b0);
                end
            end
            else if (sel < 12)
                load_alphabet(($urandom_range(9) == 0) ? $urandom_range(17, 92)
                                                       : $urandom_range(2, 12),
                              $urandom_range(4) == 0);
            else if (sel < 80)
                push_string();
            else if (sel < 92)
            begin
                sel = $urandom_range(1, 6);
                for (int k = 1; k <= sel; k++)
                    push_item(OP_TEXT, SYMBOL_INDEX_W'($urandom_range(127)),
                              CHAR_W'($urandom_range(255)), k == sel);
            end
            else
                push_item(OP_LOAD, SYMBOL_INDEX_W'($urandom_range(127)),
                          CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        wait_sent();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // empty alphabet
        push_item(OP_TEXT, '0, "5", 1'b1);
        // binary base, last set on a load
        push_item(OP_LOAD, 7'd0, "0", 1'b1);
        push_item(OP_LOAD, 7'd1, "1", 1'b0);
        // every blank, mixed signs, digits, NUL stop, trailing junk
        push_item(OP_TEXT, '0, CH_TAB, 1'b0);
        push_item(OP_TEXT, '0, CH_LF, 1'b0);
        push_item(OP_TEXT, '0, CH_VT, 1'b0);
        push_item(OP_TEXT, '0, CH_FF, 1'b0);
        push_item(OP_TEXT, '0, CH_CR, 1'b0);
        push_item(OP_TEXT, '1, CH_SPACE, 1'b0);
        push_item(OP_TEXT, '0, CH_PLUS, 1'b0);
        push_item(OP_TEXT, '0, CH_MINUS, 1'b0);
        push_item(OP_TEXT, '0, "1", 1'b0);
        push_item(OP_TEXT, '0, "0", 1'b0);
        push_item(OP_TEXT, '0, "1", 1'b0);
        push_item(OP_TEXT, '0, CH_NUL, 1'b0);
        push_item(OP_TEXT, '0, 8'hFF, 1'b1);
        // out-of-order load, then a sign symbol
        push_item(OP_LOAD, 7'd5, "x", 1'b0);
        push_item(OP_LOAD, 7'd2, CH_MINUS, 1'b0);
        push_item(OP_TEXT, '0, "1", 1'b1);
        // restart with a leading space symbol
        push_item(OP_LOAD, 7'd0, CH_SPACE, 1'b0);
        push_item(OP_LOAD, 7'd1, "a", 1'b0);
        push_item(OP_TEXT, '0, CH_SPACE, 1'b1);
        push_item(OP_TEXT, '0, CH_MINUS, 1'b0);
        push_item(OP_TEXT, '0, "a", 1'b1);
        // top index, then NUL symbol at index 0
        push_item(OP_LOAD, 7'd127, 8'hFF, 1'b0);
        push_item(OP_LOAD, 7'd0, CH_NUL, 1'b0);
        push_item(OP_TEXT, '0, "a", 1'b1);

        // long receiver hold while strings keep arriving
        load_alphabet(10, 1'b0);
        @(negedge clk);
        hold_req = 1'b1;
        repeat (15)
            push_string();
        @(negedge clk);
        hold_req = 1'b0;
        wait_sent();

        run_phase(0, 0);
        run_phase(70, 0);
        run_phase(0, 70);
        run_phase(31, 31);

        while (parsed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
